// ----- src/wfpa_pkg.sv -----
// ============================================================================
// wfpa_pkg
// Shared types and constants for the worst-fit partition allocator: transfer
// payloads, item kind codes, controller states and per-cell control.
// ============================================================================
package wfpa_pkg;

	// default build values for the top-level parameters
	localparam int MAX_PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF      = 16;

	// fixed field widths of the transfer payloads
	localparam int SIZE_FIELD_W  = 16;
	localparam int INDEX_FIELD_W = 4;
	localparam int LEFT_FIELD_W  = 16;

	// item kind codes
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_ALLOC = 1'b1;

	// input item
	typedef struct packed {
		logic                    kind;
		logic [SIZE_FIELD_W-1:0] size;
	} item_t;

	// result item
	typedef struct packed {
		logic                     granted;
		logic [INDEX_FIELD_W-1:0] partition_index;
		logic [LEFT_FIELD_W-1:0]  leftover;
	} result_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// per-cell control from the controller
	typedef struct packed {
		logic wr;    // load a new partition into this cell
		logic take;  // this cell won the scan: mark used, shrink
	} cell_ctl_t;

endpackage

// ----- src/wfpa_cell.sv -----
// ============================================================================
// wfpa_cell
// One partition slot of the scan chain. Holds the partition size and used
// flag, and each cycle passes the best candidate seen so far to its neighbour.
// ============================================================================
module wfpa_cell #(
	parameter int SIZE_BITS = wfpa_pkg::SIZE_BITS_DEF,
	parameter int IDX_W     = 4,
	parameter int INDEX     = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfpa_pkg::cell_ctl_t  ctl,
	input  logic [SIZE_BITS-1:0] wr_size,
	input  logic [SIZE_BITS-1:0] req_size,
	input  logic                 loaded,
	input  logic                 found_in,
	input  logic [IDX_W-1:0]     idx_in,
	input  logic [SIZE_BITS-1:0] size_in,
	output logic                 found_out,
	output logic [IDX_W-1:0]     idx_out,
	output logic [SIZE_BITS-1:0] size_out
);
	import wfpa_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [SIZE_BITS-1:0] part_size_q;
	logic                 used_q;
	logic                 fits;
	logic                 better;
	logic                 found_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] best_size_q;

	// stored partition: payload without reset
	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			part_size_q <= wr_size;
		end else if (ctl.take) begin
			part_size_q <= part_size_q - req_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.wr) begin
			used_q <= 1'b0;
		end else if (ctl.take) begin
			used_q <= 1'b1;
		end
	end

	// compare against the candidate from the lower-index side
	assign fits   = loaded && !used_q && (part_size_q >= req_size);
	assign better = fits && (!found_in || (part_size_q > size_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found_in || fits;
		end
	end

	always_ff @(posedge clk) begin
		if (better) begin
			idx_q       <= MY_IDX;
			best_size_q <= part_size_q;
		end else begin
			idx_q       <= idx_in;
			best_size_q <= size_in;
		end
	end

	assign found_out = found_q;
	assign idx_out   = idx_q;
	assign size_out  = best_size_q;

endmodule

// ----- src/worst_fit_partition_allocator_top.sv -----
// ============================================================================
// worst_fit_partition_allocator_top
// Fixed-partition worst-fit allocator built as a row of partition cells.
// ============================================================================
// Usage:
//   The item channel (item_valid/item_ready/item) takes loads and requests.
//   A load (kind 0) appends a partition size to the next free cell; once
//   MAX_PARTITIONS cells are loaded further loads are dropped and give no
//   result.
//   A request (kind 1) sends a candidate down the cell chain, one cell per
//   cycle, so the scan length is set by the chain length: a request occupies
//   the block through accept, the MAX_PARTITIONS cells and commit. The
//   winning cell is marked used and shrunk by the request.
//   One result transfer per request leaves on result_valid/result_ready,
//   registered; granted 0 comes with index 0 and leftover 0.
//   The result register parts the channels: loads keep flowing while a
//   result waits. If a finished scan finds the result register still full,
//   the commit waits in place until the receiver takes the old result.
//   Reset clears the used flags, the load count and all handshake state;
//   stored sizes are only read once loaded.
// ============================================================================
module worst_fit_partition_allocator_top #(
	parameter int MAX_PARTITIONS = wfpa_pkg::MAX_PARTITIONS_DEF,
	parameter int SIZE_BITS      = wfpa_pkg::SIZE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  wfpa_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output wfpa_pkg::result_t result
);
	import wfpa_pkg::*;

	localparam int IDX_W = $clog2(MAX_PARTITIONS);
	localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q;
	logic [IDX_W-1:0]     scan_q;
	logic [SIZE_BITS-1:0] req_size_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 accept;
	logic                 load_acc;
	logic                 emit;
	logic [SIZE_BITS+SIZE_FIELD_W-1:0] size_ext;
	logic [SIZE_BITS-1:0] size_in;
	logic [SIZE_BITS-1:0] left;
	logic [SIZE_BITS+LEFT_FIELD_W-1:0] left_ext;
	logic [IDX_W+INDEX_FIELD_W-1:0]    idx_ext;

	cell_ctl_t            ctl [MAX_PARTITIONS];
	logic                 ch_found [MAX_PARTITIONS+1];
	logic [IDX_W-1:0]     ch_idx   [MAX_PARTITIONS+1];
	logic [SIZE_BITS-1:0] ch_size  [MAX_PARTITIONS+1];

	// input size to internal width
	assign size_ext = {{SIZE_BITS{1'b0}}, item.size};
	assign size_in  = size_ext[SIZE_BITS-1:0];

	assign accept   = item_valid && item_ready;
	assign load_acc = accept && (item.kind == KIND_LOAD);

	// chain head: nothing found yet
	assign ch_found[0] = 1'b0;
	assign ch_idx[0]   = '0;
	assign ch_size[0]  = '0;

	// row of partition cells
	for (genvar i = 0; i < MAX_PARTITIONS; i++) begin : g_cell
		assign ctl[i].wr   = load_acc && (count_q == CNT_W'(i));
		assign ctl[i].take = emit && ch_found[MAX_PARTITIONS]
			&& (ch_idx[MAX_PARTITIONS] == IDX_W'(i));

		wfpa_cell #(
			.SIZE_BITS(SIZE_BITS),
			.IDX_W    (IDX_W),
			.INDEX    (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.wr_size  (size_in),
			.req_size (req_size_q),
			.loaded   (count_q > CNT_W'(i)),
			.found_in (ch_found[i]),
			.idx_in   (ch_idx[i]),
			.size_in  (ch_size[i]),
			.found_out(ch_found[i+1]),
			.idx_out  (ch_idx[i+1]),
			.size_out (ch_size[i+1])
		);
	end

	// controller: next state and handshakes
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		emit       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid && item.kind == KIND_ALLOC) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_q == IDX_W'(MAX_PARTITIONS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load_acc && count_q != CNT_W'(MAX_PARTITIONS)) begin
				count_q <= count_q + 1'b1;
			end
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
		end
	end

	// request size held for the whole scan
	always_ff @(posedge clk) begin
		if (accept) begin
			req_size_q <= size_in;
		end
	end

	// result formatting from the chain tail
	assign left     = ch_size[MAX_PARTITIONS] - req_size_q;
	assign left_ext = {{LEFT_FIELD_W{1'b0}}, left};
	assign idx_ext  = {{INDEX_FIELD_W{1'b0}}, ch_idx[MAX_PARTITIONS]};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.granted <= ch_found[MAX_PARTITIONS];
			if (ch_found[MAX_PARTITIONS]) begin
				result_q.partition_index <= idx_ext[INDEX_FIELD_W-1:0];
				result_q.leftover        <= left_ext[LEFT_FIELD_W-1:0];
			end else begin
				result_q.partition_index <= '0;
				result_q.leftover        <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ----- src/wfpa_checker.sv -----
// ============================================================================
// wfpa_checker
// Port-level checks for the worst-fit partition allocator, bound to the top.
// ============================================================================
module wfpa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input wfpa_pkg::item_t   item,
	input logic              result_valid,
	input logic              result_ready,
	input wfpa_pkg::result_t result
);
	import wfpa_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a refusal reports neither index nor leftover
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.granted |->
			result.partition_index == '0 && result.leftover == '0)
		else $error("refused result carries data");

	// a request transfer starts a scan that blocks the item channel
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.kind == KIND_ALLOC |=> !item_ready)
		else $error("item taken during scan");

	// a load does not stall the item channel
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.kind == KIND_LOAD |=> item_ready)
		else $error("load stalled the item channel");

endmodule

bind worst_fit_partition_allocator_top wfpa_checker u_wfpa_checker (.*);

// ----- tb/worst_fit_partition_allocator_top_test.sv -----
// ============================================================================
// worst_fit_partition_allocator_top_test
// Self-checking bench for the worst-fit partition allocator. Loads and
// requests go in on the item channel; a scoreboard keeps its own copy of
// the partition table, predicts each request's grant, index and leftover,
// and compares every result transfer against the oldest prediction.
// ============================================================================
module worst_fit_partition_allocator_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wfpa_pkg::*;

	localparam int NUM_PARTS   = MAX_PARTITIONS_DEF;
	localparam int SCAN_CYCLES = NUM_PARTS + 2;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	// partition table mirror and expected grants
	class alloc_scoreboard;
		logic [SIZE_FIELD_W-1:0] part_size[NUM_PARTS];
		bit                      part_used[NUM_PARTS];
		int unsigned             loaded;
		result_t                 grant_q[$];
		int unsigned             errors;
		int unsigned             grants;
		int unsigned             misses;
		int unsigned             dropped_loads;

		function new();
			foreach (part_size[i]) begin
				part_size[i] = '0;
				part_used[i] = 1'b0;
			end
			loaded        = 0;
			errors        = 0;
			grants        = 0;
			misses        = 0;
			dropped_loads = 0;
		endfunction

		// work out the outcome of one accepted item
		function void note_item(item_t it);
			bit                      found;
			int unsigned             best;
			logic [SIZE_FIELD_W-1:0] best_size;
			result_t                 res;
			found     = 1'b0;
			best      = 0;
			best_size = '0;
			res       = '0;
			if (it.kind == KIND_LOAD) begin
				if (loaded < NUM_PARTS) begin
					part_size[loaded] = it.size;
					part_used[loaded] = 1'b0;
					loaded++;
				end else begin
					dropped_loads++;
				end
				return;
			end
			// largest free partition that fits; strict compare keeps the lowest index
			for (int unsigned i = 0; i < loaded; i++) begin
				if (!part_used[i] && part_size[i] >= it.size &&
				    (!found || part_size[i] > best_size)) begin
					found     = 1'b1;
					best      = i;
					best_size = part_size[i];
				end
			end
			if (found) begin
				part_used[best]     = 1'b1;
				part_size[best]     = best_size - it.size;
				res.granted         = 1'b1;
				res.partition_index = best[INDEX_FIELD_W-1:0];
				res.leftover        = part_size[best];
				grants++;
			end else begin
				misses++;
			end
			grant_q.push_back(res);
		endfunction

		// compare one result transfer with the oldest expectation
		function void check_result(result_t got);
			result_t exp_res;
			if (grant_q.size() == 0) begin
				$error("unexpected result transfer: granted %0d index %0d leftover %0d",
				       got.granted, got.partition_index, got.leftover);
				errors++;
				return;
			end
			exp_res = grant_q.pop_front();
			if (got.granted !== exp_res.granted) begin
				$error("granted: expected %0d, got %0d", exp_res.granted, got.granted);
				errors++;
			end
			if (got.partition_index !== exp_res.partition_index) begin
				$error("partition_index: expected %0d, got %0d",
				       exp_res.partition_index, got.partition_index);
				errors++;
			end
			if (got.leftover !== exp_res.leftover) begin
				$error("leftover: expected %0d, got %0d", exp_res.leftover, got.leftover);
				errors++;
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	alloc_scoreboard sb;
	int unsigned     send_idle;
	int unsigned     recv_idle;
	bit              hold_req;
	int unsigned     loads_sent;

	worst_fit_partition_allocator_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("worst_fit_partition_allocator_top_test failed");
		$finish;
	end

	// offer one item, with random idle cycles first; valid stays up afterwards
	task automatic send_item(logic kind, logic [SIZE_FIELD_W-1:0] size);
		item_t it;
		it.kind = kind;
		it.size = size;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
		sb.note_item(it);
		if (kind == KIND_LOAD)
			loads_sent++;
	endtask

	// random loads and requests; loads only while the total sent is under this phase's cap
	task automatic random_phase(int unsigned n_items, int unsigned load_cap);
		logic [SIZE_FIELD_W-1:0] sz;
		int unsigned             pick;
		for (int unsigned n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			if (loads_sent < load_cap && $urandom_range(99) < 15) begin
				if (pick < 10)      sz = '0;
				else if (pick < 20) sz = '1;
				else if (pick < 65) sz = SIZE_FIELD_W'($urandom_range(4095));
				else                sz = SIZE_FIELD_W'($urandom);
				send_item(KIND_LOAD, sz);
			end else begin
				if (pick < 20)      sz = '0;
				else if (pick < 28) sz = '1;
				else if (pick < 70) sz = SIZE_FIELD_W'($urandom_range(4095));
				else                sz = SIZE_FIELD_W'($urandom);
				send_item(KIND_ALLOC, sz);
			end
		end
	endtask

	// result side: check each transfer, then pick the next ready
	initial begin
		int unsigned hold_left;
		hold_left    = 0;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_valid && result_ready)
				sb.check_result(result);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle);
			end
		end
	end

	// stimulus and end of run
	initial begin
		sb         = new();
		send_idle  = 32;
		recv_idle  = 85;
		hold_req   = 1'b0;
		loads_sent = 0;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, exact fit, tie, zero-size request
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_ALLOC, 16'hFFFF);
		send_item(KIND_LOAD,  16'hFFFF);
		send_item(KIND_LOAD,  16'd0);
		send_item(KIND_LOAD,  16'd100);
		send_item(KIND_LOAD,  16'd100);
		send_item(KIND_ALLOC, 16'hFFFF);
		send_item(KIND_ALLOC, 16'd101);
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_ALLOC, 16'd100);
		send_item(KIND_ALLOC, 16'd1);
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_ALLOC, 16'd0);
		send_item(KIND_LOAD,  16'h5555);
		send_item(KIND_LOAD,  16'hAAAA);
		send_item(KIND_ALLOC, 16'h5555);

		// random phases: receiver then sender idling, then full rate with a long result stall
		random_phase(580, 10);
		send_idle = 85;
		recv_idle = 32;
		random_phase(580, 15);
		send_idle = 0;
		recv_idle = 0;
		hold_req  = 1'b1;
		random_phase(580, 30);
		item_valid <= 1'b0;

		while (sb.grant_q.size() != 0) @(posedge clk);
		repeat (SCAN_CYCLES + 8) @(posedge clk);

		$display("Covered %0d loads (%0d dropped on a full table), %0d grants, %0d refusals.",
		         loads_sent, sb.dropped_loads, sb.grants, sb.misses);
		$display("Idling on each side in turn, full rate and a long result stall; %0d errors.",
		         sb.errors);
		if (sb.errors == 0) begin
			$display("worst_fit_partition_allocator_top_test passed");
		end else begin
			$display("worst_fit_partition_allocator_top_test failed");
		end
		$finish;
	end

endmodule
